// ===== design/cbez_pkg.sv =====
// shared types, constants and the microprogram for the cubic bezier core
`timescale 1ns / 1ps

package cbez_pkg;

  localparam int COORD_BITS = 24;
  localparam int U_BITS     = 16;
  localparam int NUM_POINTS = 4;
  localparam int IDX_BITS   = 2;
  localparam int STEP_BITS  = 4;
  // lerp datapath widths: difference, product, quotient after the shift
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = DIFF_BITS + U_BITS + 2;
  localparam int Q_BITS     = PROD_BITS - U_BITS;

  localparam logic [U_BITS:0] U_ONE = (U_BITS + 1)'(1) << U_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [U_BITS:0]              uparam_t;
  typedef logic [IDX_BITS-1:0]          pidx_t;
  typedef logic [STEP_BITS-1:0]         step_t;

  // opcodes of an input word
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_t;

  // control word of the microprogram
  typedef struct packed {
    logic  iss;   // issue one lerp per coordinate lane
    pidx_t sel;   // lerp operands are lv[sel] and lv[sel+1], result to lv[sel]
    logic  emit;  // move lv[0] to the output register, stall until it is free
  } uword_t;

  // control that the sequencer hands to each lane
  typedef struct packed {
    logic  start;
    logic  iss;
    pidx_t sel;
  } lane_ctrl_t;

  // de casteljau program: three levels of lerps, then emit
  // a lerp result is written back only after the lane's stage 2 registers, so bubbles keep each
  // operand read behind the write that produces it
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w = '{iss: 1'b0, sel: '0, emit: 1'b0};
    unique case (step)
      4'd0: w = '{iss: 1'b1, sel: 2'd0, emit: 1'b0};
      4'd1: w = '{iss: 1'b1, sel: 2'd1, emit: 1'b0};
      4'd2: w = '{iss: 1'b1, sel: 2'd2, emit: 1'b0};
      4'd3: w = '{iss: 1'b1, sel: 2'd0, emit: 1'b0};
      4'd4: w = '{iss: 1'b1, sel: 2'd1, emit: 1'b0};
      4'd5: w = '{iss: 1'b0, sel: 2'd0, emit: 1'b0};
      4'd6: w = '{iss: 1'b1, sel: 2'd0, emit: 1'b0};
      4'd7: w = '{iss: 1'b0, sel: 2'd0, emit: 1'b0};
      default: w = '{iss: 1'b0, sel: 2'd0, emit: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== design/cbez_seq.sv =====
// microcode sequencer: step counter, program rom and emit control
`timescale 1ns / 1ps

module cbez_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                out_free,
  output cbez_pkg::lane_ctrl_t ctrl,
  output logic                emit,
  output logic                busy
);
  import cbez_pkg::*;

  step_t  step;
  uword_t word;

  // current control word
  always_comb begin
    word = ucode_rom(step);
  end

  assign ctrl.start = start;
  assign ctrl.iss   = busy & word.iss;
  assign ctrl.sel   = word.sel;
  assign emit       = busy & word.emit & out_free;

  // step counter; the emit step holds until the output register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (word.emit) begin
        if (out_free) begin
          busy <= 1'b0;
        end
      end else begin
        step <= step + step_t'(1);
      end
    end
  end

endmodule

// ===== design/cbez_lane.sv =====
// one coordinate lane: level registers and a two stage rounding lerp
`timescale 1ns / 1ps

module cbez_lane (
  input  logic                                       clk,
  input  logic                                       rst,
  input  cbez_pkg::lane_ctrl_t                       ctrl,
  input  cbez_pkg::coord_t [cbez_pkg::NUM_POINTS-1:0] pts,
  input  cbez_pkg::uparam_t                          u,
  output cbez_pkg::coord_t                           result
);
  import cbez_pkg::*;

  coord_t [NUM_POINTS-1:0] lv;

  pidx_t                       sel_b;
  logic signed [DIFF_BITS-1:0] diff;
  logic signed [PROD_BITS-1:0] prod;

  logic                        v_r;
  pidx_t                       dst_r;
  coord_t                      a_r;
  logic signed [PROD_BITS-1:0] prod_r;

  logic signed [PROD_BITS-1:0] rnd;
  logic signed [Q_BITS-1:0]    q;
  logic signed [Q_BITS-1:0]    sum;
  coord_t                      sat;

  // stage 1: difference and product
  always_comb begin
    sel_b = ctrl.sel + pidx_t'(1);
    diff  = DIFF_BITS'(lv[sel_b]) - DIFF_BITS'(lv[ctrl.sel]);
    prod  = PROD_BITS'(diff) * $signed(PROD_BITS'({1'b0, u}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r <= 1'b0;
    end else begin
      v_r <= ctrl.iss;
    end
  end

  always_ff @(posedge clk) begin
    dst_r  <= ctrl.sel;
    a_r    <= lv[ctrl.sel];
    prod_r <= prod;
  end

  // stage 2: round half up, floor shift, add and saturate
  always_comb begin
    rnd = prod_r + (PROD_BITS'(1) <<< (U_BITS - 1));
    q   = rnd[PROD_BITS-1:U_BITS];
    sum = Q_BITS'(a_r) + q;
    if (sum > Q_BITS'(coord_t'({1'b0, {(COORD_BITS-1){1'b1}}}))) begin
      sat = {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (sum < Q_BITS'(coord_t'({1'b1, {(COORD_BITS-1){1'b0}}}))) begin
      sat = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat = sum[COORD_BITS-1:0];
    end
  end

  // level registers: loaded at start, written back by stage 2
  always_ff @(posedge clk) begin
    priority if (ctrl.start) begin
      lv <= pts;
    end else if (v_r) begin
      lv[dst_r] <= sat;
    end
  end

  assign result = lv[0];

endmodule

// ===== design/cubic_bezier_point_eval_core.sv =====
// top level: control point store, three coordinate lanes and output register
// an accepted evaluate loads the lanes, runs the microprogram, then emits its point to the output register
// in_stall stays high until that emit, so a further evaluate waits (6 lerps through a 2-stage multiply
//   lane per coordinate with two bubbles, run by the microprogram); a load does not stall input
// a finished point waits in the output register; a later evaluate holds input until it emits
// reset clears the sequencer and output valid; control points are undefined
`timescale 1ns / 1ps

module cubic_bezier_point_eval_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  opcode,
  input  logic [1:0]            point_index,
  input  cbez_pkg::coord_t      point_x,
  input  cbez_pkg::coord_t      point_y,
  input  cbez_pkg::coord_t      point_z,
  input  cbez_pkg::uparam_t     param_u,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cbez_pkg::coord_t      curve_x,
  output cbez_pkg::coord_t      curve_y,
  output cbez_pkg::coord_t      curve_z
);
  import cbez_pkg::*;

  coord_t [NUM_POINTS-1:0] cp_x;
  coord_t [NUM_POINTS-1:0] cp_y;
  coord_t [NUM_POINTS-1:0] cp_z;
  uparam_t                 u_r;

  logic       accept;
  logic       start;
  logic       out_free;
  logic       emit;
  logic       busy;
  lane_ctrl_t ctrl;
  coord_t     res_x;
  coord_t     res_y;
  coord_t     res_z;

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;
  assign start    = accept & (opcode == OP_EVAL);
  assign out_free = ~out_valid | ~out_stall;

  // control point store and clamped curve parameter
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_LOAD) begin
      cp_x[point_index] <= point_x;
      cp_y[point_index] <= point_y;
      cp_z[point_index] <= point_z;
    end
    if (start) begin
      u_r <= (param_u > U_ONE) ? U_ONE : param_u;
    end
  end

  cbez_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl),
    .emit     (emit),
    .busy     (busy)
  );

  cbez_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .pts    (cp_x),
    .u      (u_r),
    .result (res_x)
  );

  cbez_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .pts    (cp_y),
    .u      (u_r),
    .result (res_y)
  );

  cbez_lane u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .pts    (cp_z),
    .u      (u_r),
    .result (res_z)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      curve_x <= res_x;
      curve_y <= res_y;
      curve_z <= res_z;
    end
  end

endmodule
